FILE: rtl/core/fifo_queued_mutex_unit_core_defines.svh
// ----------------------------------------------------------------------------
// fifo queued mutex unit: assertion macros
// concurrent check macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUED_MUTEX_UNIT_CORE_DEFINES_SVH
`define FIFO_QUEUED_MUTEX_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent on the same edge
`define FQM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fqm implication check failed");
// expression holds on every edge out of reset
`define FQM_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("fqm invariant check failed");
`else
`define FQM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define FQM_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`endif

`endif

FILE: rtl/core/fqm_pkg.sv
// ----------------------------------------------------------------------------
// fqm_pkg
// shared types, codes and sizes of the fifo queued mutex unit
// ----------------------------------------------------------------------------
package fqm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int ID_W        = 8;
    localparam int MODE_W      = 3;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [ID_W-1:0] ID_MASK = ID_W'((32'd1 << ID_BITS) - 32'd1);

    // request mode codes as they arrive on the stream
    localparam logic [MODE_W-1:0] MODE_LOCK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRY    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNLOCK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

    typedef enum logic [2:0] {
        OP_LOCK,
        OP_TRY,
        OP_UNLOCK,
        OP_CANCEL,
        OP_REMOVE,
        OP_STATUS
    } op_t;

    typedef enum logic [1:0] {
        ACT_GRANT       = 2'd0,
        ACT_CANCEL_WAKE = 2'd1,
        ACT_MARK        = 2'd2,
        ACT_STATUS      = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DRAIN,
        ST_SCAN,
        ST_SETTLE,
        ST_FINAL
    } back_state_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] req;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef struct packed {
        action_t            action;
        logic [ID_W-1:0]    target_id;
        logic               success;
        logic               overflow;
        logic               locked;
        logic [COUNT_W-1:0] wait_count;
        logic               cancelled;
        logic               last;
    } result_t;

endpackage

FILE: rtl/core/fifo_queued_mutex_unit_core.sv
// a request goes through command queue, engine state and output register to its first result
// lock, try-lock, status, plain unlock: a status result, after a grant or mark if one goes out
// cancel wakes each of N waiters, owner unlock while cancelled sends a mark and then the wakes
// one wake a cycle unless the output stalls; remove walks the wait queue one entry a cycle
// the 2-entry command queue takes new requests while the engine is busy
// reset (aresetn low, synchronous): unlocked, no waiters, cancel flag clear, outputs idle
// ----------------------------------------------------------------------------
// fifo_queued_mutex_unit_core
// hardware lock with owner, fifo of waiters and a sticky cancel flag
// ----------------------------------------------------------------------------
`include "fifo_queued_mutex_unit_core_defines.svh"

module fifo_queued_mutex_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[2:0], requester_id[10:3], zero pad
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // action[1:0], target_id[9:2], success[10],
                                   // overflow[11], locked[12], wait_count[17:13],
                                   // cancelled[18], zero pad
    output logic        m_tlast
);
    import fqm_pkg::*;

    cmd_push_t push;
    cmd_head_t head;
    logic      queue_full;
    logic      pop;
    result_t   res;
    logic      out_status;
    logic      out_grant;
    logic      out_wake;
    logic      count_ok;

    // front end: decode and mask the request
    fqm_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .mode         (s_tdata[2:0]),
        .requester_id (s_tdata[10:3]),
        .queue_full   (queue_full),
        .push         (push)
    );

    // decoupling queue between the front end and the lock engine
    fqm_cmd_queue u_cmd_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    // lock engine with registered result output
    fqm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (res)
    );

    // result packing, first field in the low bits
    assign m_tdata = {5'd0, res.cancelled, res.wait_count, res.locked, res.overflow,
                      res.success, res.target_id, res.action};
    assign m_tlast = res.last;

    // result kind decode for the checks below
    assign out_status = (res.action == ACT_STATUS);
    assign out_grant  = m_tvalid && (res.action == ACT_GRANT);
    assign out_wake   = m_tvalid && (res.action == ACT_CANCEL_WAKE);
    assign count_ok   = !m_tvalid || (res.wait_count <= COUNT_W'(QUEUE_DEPTH));

    // the final status transaction and only that one closes a request
    `FQM_ASSERT_IMPLY(a_last_is_status, aclk, aresetn, m_tvalid, m_tlast == out_status)
    // a grant always leaves the lock owned
    `FQM_ASSERT_IMPLY(a_grant_locked, aclk, aresetn, out_grant, res.locked)
    // cancel wakes only come out of a drain: queue empty and flag set
    `FQM_ASSERT_IMPLY(a_wake_drained, aclk, aresetn, out_wake, res.cancelled && res.wait_count == '0)
    // a reported waiter count never exceeds the queue size
    `FQM_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_ok)

endmodule

FILE: rtl/core/fqm_front.sv
// ----------------------------------------------------------------------------
// fqm_front
// takes requests off the input stream and decodes them into commands
// ----------------------------------------------------------------------------
module fqm_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fqm_pkg::MODE_W-1:0] mode,
    input  logic [fqm_pkg::ID_W-1:0]  requester_id,
    input  logic                      queue_full,
    output fqm_pkg::cmd_push_t        push
);
    import fqm_pkg::*;

    op_t op;

    // unused mode codes fall back to a status query
    always_comb begin
        unique case (mode)
            MODE_LOCK:   op = OP_LOCK;
            MODE_TRY:    op = OP_TRY;
            MODE_UNLOCK: op = OP_UNLOCK;
            MODE_CANCEL: op = OP_CANCEL;
            MODE_REMOVE: op = OP_REMOVE;
            default:     op = OP_STATUS;
        endcase
    end

    assign s_tready     = !queue_full;
    assign push.valid   = s_tvalid && !queue_full;
    assign push.cmd.op  = op;
    assign push.cmd.req = requester_id & ID_MASK;

endmodule

FILE: rtl/core/fqm_cmd_queue.sv
// ----------------------------------------------------------------------------
// fqm_cmd_queue
// short command queue between the decode front and the lock engine
// ----------------------------------------------------------------------------
module fqm_cmd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  fqm_pkg::cmd_push_t push,
    output logic               full,
    input  logic               pop,
    output fqm_pkg::cmd_head_t head
);
    import fqm_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_pop;

    assign full       = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push.valid && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

FILE: rtl/core/fqm_back.sv
// ----------------------------------------------------------------------------
// fqm_back
// lock engine: owner, wait queue and cancel flag, emits result transactions
// ----------------------------------------------------------------------------
module fqm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  fqm_pkg::cmd_head_t head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output fqm_pkg::result_t   m_result
);
    import fqm_pkg::*;

    back_state_t        state_reg, state_next;
    logic               owner_valid_reg, owner_valid_next;
    logic [ID_W-1:0]    owner_id_reg, owner_id_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cancel_reg, cancel_next;
    logic [ID_W-1:0]    q_reg [QUEUE_DEPTH];

    logic [ID_W-1:0]    cur_req_reg, cur_req_next;
    logic               succ_reg, succ_next;
    logic               ovf_reg, ovf_next;
    action_t            pre_action_reg, pre_action_next;
    logic [ID_W-1:0]    pre_target_reg, pre_target_next;
    logic               drain_pend_reg, drain_pend_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] drain_n_reg, drain_n_next;

    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic               q_wr_en;
    logic [ID_W-1:0]    q_wr_data;
    logic               q_shift_en;
    logic [IDX_W-1:0]   q_shift_pos;

    logic               out_free;
    logic               emit;
    result_t            emit_data;
    logic               own_match;
    logic               q_empty;
    logic               q_full;
    logic [ID_W-1:0]    q_rd;
    logic               scan_end;
    logic               scan_hit;

    assign out_free  = !out_valid_reg || m_ready;
    assign own_match = owner_valid_reg && (owner_id_reg == head.cmd.req);
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign q_rd      = q_reg[idx_reg[IDX_W-1:0]];
    assign scan_end  = (idx_reg == count_reg);
    assign scan_hit  = !scan_end && (q_rd == cur_req_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    unique case (head.cmd.op)
                        OP_LOCK:   state_next = owner_valid_reg ? ST_FINAL : ST_PRE;
                        OP_UNLOCK: state_next = (cancel_reg || (own_match && !q_empty))
                                                ? ST_PRE : ST_FINAL;
                        OP_CANCEL: state_next = q_empty ? ST_FINAL : ST_DRAIN;
                        OP_REMOVE: state_next = ST_SCAN;
                        default:   state_next = ST_FINAL;
                    endcase
                end
            end
            ST_PRE: begin
                if (out_free) begin
                    state_next = drain_pend_reg ? ST_DRAIN : ST_FINAL;
                end
            end
            ST_DRAIN: begin
                if (out_free && (idx_reg + 1'b1 == drain_n_reg)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_SCAN: begin
                if (scan_end || scan_hit) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = (!owner_valid_reg && !q_empty) ? ST_PRE : ST_FINAL;
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and emission control
    always_comb begin
        owner_valid_next = owner_valid_reg;
        owner_id_next    = owner_id_reg;
        count_next       = count_reg;
        cancel_next      = cancel_reg;
        cur_req_next     = cur_req_reg;
        succ_next        = succ_reg;
        ovf_next         = ovf_reg;
        pre_action_next  = pre_action_reg;
        pre_target_next  = pre_target_reg;
        drain_pend_next  = drain_pend_reg;
        idx_next         = idx_reg;
        drain_n_next     = drain_n_reg;
        q_wr_en          = 1'b0;
        q_wr_data        = head.cmd.req;
        q_shift_en       = 1'b0;
        q_shift_pos      = '0;
        pop              = 1'b0;
        emit             = 1'b0;
        emit_data        = '0;

        // status fields already hold the values after the whole request
        emit_data.locked     = owner_valid_reg;
        emit_data.wait_count = count_reg;
        emit_data.cancelled  = cancel_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop             = 1'b1;
                    cur_req_next    = head.cmd.req;
                    succ_next       = 1'b0;
                    ovf_next        = 1'b0;
                    drain_pend_next = 1'b0;
                    idx_next        = '0;
                    drain_n_next    = count_reg;
                    pre_action_next = ACT_GRANT;
                    pre_target_next = head.cmd.req;
                    unique case (head.cmd.op)
                        OP_LOCK: begin
                            if (!owner_valid_reg) begin
                                owner_valid_next = 1'b1;
                                owner_id_next    = head.cmd.req;
                            end else if (q_full) begin
                                ovf_next = 1'b1;
                            end else begin
                                q_wr_en    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_TRY: begin
                            if (!owner_valid_reg) begin
                                owner_valid_next = 1'b1;
                                owner_id_next    = head.cmd.req;
                                succ_next        = 1'b1;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!own_match) begin
                                pre_action_next = ACT_MARK;
                            end else if (cancel_reg) begin
                                pre_action_next  = ACT_MARK;
                                pre_target_next  = owner_id_reg;
                                drain_pend_next  = !q_empty;
                                count_next       = '0;
                                owner_valid_next = 1'b0;
                                owner_id_next    = '0;
                            end else if (!q_empty) begin
                                // hand over to the head of the queue
                                owner_id_next   = q_reg[0];
                                pre_target_next = q_reg[0];
                                q_shift_en      = 1'b1;
                                count_next      = count_reg - 1'b1;
                            end else begin
                                owner_valid_next = 1'b0;
                                owner_id_next    = '0;
                            end
                        end
                        OP_CANCEL: begin
                            cancel_next = 1'b1;
                            count_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRE: begin
                emit                = 1'b1;
                emit_data.action    = pre_action_reg;
                emit_data.target_id = pre_target_reg;
            end
            ST_DRAIN: begin
                // entries stay in place until the next write, count is already zero
                emit                = 1'b1;
                emit_data.action    = ACT_CANCEL_WAKE;
                emit_data.target_id = q_rd;
                if (out_free) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    q_shift_en  = 1'b1;
                    q_shift_pos = idx_reg[IDX_W-1:0];
                    count_next  = count_reg - 1'b1;
                    succ_next   = 1'b1;
                end else if (!scan_end) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SETTLE: begin
                if (!owner_valid_reg && !q_empty) begin
                    owner_valid_next = 1'b1;
                    owner_id_next    = q_reg[0];
                    pre_action_next  = ACT_GRANT;
                    pre_target_next  = q_reg[0];
                    q_shift_en       = 1'b1;
                    count_next       = count_reg - 1'b1;
                end
            end
            ST_FINAL: begin
                emit                = 1'b1;
                emit_data.action    = ACT_STATUS;
                emit_data.target_id = cur_req_reg;
                emit_data.success   = succ_reg;
                emit_data.overflow  = ovf_reg;
                emit_data.last      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            count_reg       <= '0;
            cancel_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            owner_id_reg    <= owner_id_next;
            count_reg       <= count_next;
            cancel_reg      <= cancel_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_req_reg    <= cur_req_next;
        succ_reg       <= succ_next;
        ovf_reg        <= ovf_next;
        pre_action_reg <= pre_action_next;
        pre_target_reg <= pre_target_next;
        drain_pend_reg <= drain_pend_next;
        idx_reg        <= idx_next;
        drain_n_reg    <= drain_n_next;
        out_data_reg   <= out_data_next;
    end

    // wait queue, head at entry zero; removal closes the gap in one step
    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            q_reg[count_reg[IDX_W-1:0]] <= q_wr_data;
        end
        if (q_shift_en) begin
            for (int m = 0; m < QUEUE_DEPTH - 1; m++) begin
                if (IDX_W'(m) >= q_shift_pos) begin
                    q_reg[m] <= q_reg[m+1];
                end
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule
